// ===== rtl/pressure_temperature_compensation_assert.svh =====
// assertion macros shared by the checker of the compensation block
// depends on nothing; the including module supplies clk and rst_n
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH

// same-cycle implication
`define PTC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptc assertion failed");

// next-cycle implication
`define PTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptc assertion failed");

`endif

// ===== rtl/ptc_pkg.sv =====
// shared types and constants of the pressure and temperature compensation block
// no dependencies
`default_nettype none

package ptc_pkg;

    // register stages from an accepted word to its result in the output register
    localparam int unsigned LATENCY = 79;
    localparam int unsigned DIV_STAGES = 64;

    typedef enum logic [1:0] {
        REG_TEMP_CAL,
        REG_PRESS_A,
        REG_PRESS_B,
        REG_PRESS_C
    } reg_idx_t;

    // data carried alongside the pressure path
    typedef struct packed {
        logic [15:0] tc;
        logic        fault;
    } side_t;

endpackage

`default_nettype wire

// ===== rtl/ptc_mul64.sv =====
// 64 by 64 multiplier, product modulo 2^64, two register stages
// built from three 32 by 32 partial products; no dependencies
`default_nettype none

module ptc_mul64 (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic      [63:0] p
);

    logic [63:0] ll_reg, ll_next;
    logic [31:0] cr_reg, cr_next;
    logic [63:0] p_reg;
    logic [63:0] lh, hl;

    always_comb
    begin
        ll_next = a[31:0] * b[31:0];
        lh      = a[31:0] * b[63:32];
        hl      = a[63:32] * b[31:0];
        cr_next = lh[31:0] + hl[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= ll_next;
            cr_reg <= cr_next;
            p_reg  <= ll_reg + {cr_reg, 32'd0};
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== rtl/pressure_temperature_compensation.sv =====
// depth: 79 register stages from an accepted input word to its result in the output register
// throughput: one word per cycle while the output is not stalled; the 64-stage radix-2 divider pipeline sets the depth
// the whole pipeline advances together and holds while a result waits at the output
// reset: rst_n clears calibration registers to zero and drops all valid bits
// depends on ptc_pkg and ptc_mul64
`default_nettype none

module pressure_temperature_compensation
    import ptc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // temperature_centi[15:0], pressure_q24_8[47:16]
    output logic      [0:0]  m_tuser,   // divide_fault[0]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] dq;
        logic [63:0] dvs;
        logic        neg;
        side_t       side;
    } div_t;

    // configuration
    logic [47:0] temp_cal_reg;
    logic [63:0] press_a_reg, press_b_reg;
    logic [15:0] press_c_reg;
    reg_idx_t    idx;

    assign idx    = reg_idx_t'(paddr[4:3]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg <= '0;
            press_a_reg  <= '0;
            press_b_reg  <= '0;
            press_c_reg  <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                REG_TEMP_CAL: temp_cal_reg <= pwdata[47:0];
                REG_PRESS_A:  press_a_reg  <= pwdata;
                REG_PRESS_B:  press_b_reg  <= pwdata;
                REG_PRESS_C:  press_c_reg  <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_TEMP_CAL: prdata = {16'd0, temp_cal_reg};
            REG_PRESS_A:  prdata = press_a_reg;
            REG_PRESS_B:  prdata = press_b_reg;
            REG_PRESS_C:  prdata = {48'd0, press_c_reg};
            default:      prdata = '0;
        endcase
    end

    logic        [15:0] t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = temp_cal_reg[15:0];
    assign t2 = temp_cal_reg[31:16];
    assign t3 = temp_cal_reg[47:32];
    assign p1 = press_a_reg[15:0];
    assign p2 = press_a_reg[31:16];
    assign p3 = press_a_reg[47:32];
    assign p4 = press_a_reg[63:48];
    assign p5 = press_b_reg[15:0];
    assign p6 = press_b_reg[31:16];
    assign p7 = press_b_reg[47:32];
    assign p8 = press_b_reg[63:48];
    assign p9 = press_c_reg;

    // pipeline control
    logic [LATENCY-1:0] valid_reg;
    logic               en;

    assign en       = !valid_reg[LATENCY-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = valid_reg[LATENCY-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[LATENCY-2:0], s_tvalid};
    end

    // stage 1: first temperature products
    logic        [19:0] adc_t, adc_p;
    logic signed [17:0] a18;
    logic signed [16:0] d17;
    logic signed [33:0] at2_next, at2_reg, dd_next, dd_reg;
    logic        [19:0] adc_p1_reg, adc_p2_reg, adc_p3_reg, adc_p4_reg;
    logic        [19:0] adc_p5_reg, adc_p6_reg;

    assign adc_t = s_tdata[19:0];
    assign adc_p = s_tdata[39:20];

    always_comb
    begin
        a18      = $signed({1'b0, adc_t[19:3]}) - $signed({1'b0, t1, 1'b0});
        d17      = $signed({1'b0, adc_t[19:4]}) - $signed({1'b0, t1});
        at2_next = a18 * t2;
        dd_next  = d17 * d17;
    end

    // stage 2
    logic signed [22:0] v1t_reg;
    logic signed [37:0] x_next, x_reg;
    logic signed [21:0] dd_sh;

    always_comb
    begin
        dd_sh  = $signed(dd_reg[33:12]);
        x_next = dd_sh * t3;
    end

    // stage 3: fine temperature
    logic signed [25:0] tf;
    logic signed [28:0] t29;
    logic signed [20:0] tcw;
    logic        [15:0] tc_next, tc3_reg, tc4_reg, tc5_reg, tc6_reg, tc7_reg;
    logic        [15:0] tc8_reg, tc9_reg;
    logic signed [26:0] pv1_next, pv1_reg;
    logic signed [23:0] xs;

    always_comb
    begin
        xs  = $signed(x_reg[37:14]);
        tf  = $signed({{3{v1t_reg[22]}}, v1t_reg}) + $signed({{2{xs[23]}}, xs});
        t29 = $signed({{3{tf[25]}}, tf}) * 29'sd5 + 29'sd128;
        tcw = $signed(t29[28:8]);
        if (tcw > 21'sd32767)
            tc_next = 16'h7fff;
        else if (tcw < -21'sd32768)
            tc_next = 16'h8000;
        else
            tc_next = tcw[15:0];
        pv1_next = $signed({tf[25], tf}) - 27'sd128000;
    end

    // stage 4: products of the pressure offset term
    logic signed [53:0] sq_next, sq_reg;
    logic signed [42:0] p5m_next, p5m_reg, p5m5_reg, p5m6_reg;
    logic signed [42:0] p2m_next, p2m_reg, p2m5_reg, p2m6_reg;

    always_comb
    begin
        sq_next  = pv1_reg * pv1_reg;
        p5m_next = pv1_reg * p5;
        p2m_next = pv1_reg * p2;
    end

    // stages 5 and 6
    logic [63:0] sq64, m_p6, m_p3;

    assign sq64 = {{10{sq_reg[53]}}, sq_reg};

    ptc_mul64 u_mul_p6 (
        .clk (clk),
        .en  (en),
        .a   (sq64),
        .b   ({{48{p6[15]}}, p6}),
        .p   (m_p6)
    );

    ptc_mul64 u_mul_p3 (
        .clk (clk),
        .en  (en),
        .a   (sq64),
        .b   ({{48{p3[15]}}, p3}),
        .p   (m_p3)
    );

    // stage 7: pressure divisor term and numerator
    logic [63:0] v2_7, v1_next, v1_reg, num0_next, num0_reg;
    logic [20:0] pp;

    always_comb
    begin
        v2_7 = m_p6 + ({{21{p5m6_reg[42]}}, p5m6_reg} << 17)
             + ({{48{p4[15]}}, p4} << 35);
        v1_next = {{8{m_p3[63]}}, m_p3[63:8]} + ({{21{p2m6_reg[42]}}, p2m6_reg} << 12);
        pp = 21'd1048576 - {1'b0, adc_p6_reg};
        num0_next = ({43'd0, pp} << 31) - v2_7;
    end

    // stages 8 and 9
    logic [63:0] m_den, m_num;

    ptc_mul64 u_mul_p1 (
        .clk (clk),
        .en  (en),
        .a   (v1_reg + 64'h0000_8000_0000_0000),
        .b   ({48'd0, p1}),
        .p   (m_den)
    );

    ptc_mul64 u_mul_k (
        .clk (clk),
        .en  (en),
        .a   (num0_reg),
        .b   (64'd3125),
        .p   (m_num)
    );

    // stage 10: magnitudes for the divider
    logic [63:0] den;
    div_t        div_in  [DIV_STAGES];
    div_t        div_out [DIV_STAGES];
    div_t        div_reg [DIV_STAGES];
    div_t        d10_next;

    always_comb
    begin
        den              = {{33{m_den[63]}}, m_den[63:33]};
        d10_next.rem     = '0;
        d10_next.dq      = m_num[63] ? 64'd0 - m_num : m_num;
        d10_next.dvs     = den[63] ? 64'd0 - den : den;
        d10_next.neg     = m_num[63] ^ den[63];
        d10_next.side.tc = tc9_reg;
        d10_next.side.fault = (den == 64'd0);
    end

    // restoring divider, one quotient bit per stage
    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        logic [64:0] trial, diff;
        logic        ge;

        if (g == 0)
        begin : g_first
            assign div_in[g] = d10_next;
        end
        else
        begin : g_rest
            assign div_in[g] = div_reg[g-1];
        end

        always_comb
        begin
            trial = {div_in[g].rem, div_in[g].dq[63]};
            diff  = trial - {1'b0, div_in[g].dvs};
            ge    = (trial >= {1'b0, div_in[g].dvs});
            div_out[g]     = div_in[g];
            div_out[g].rem = ge ? diff[63:0] : trial[63:0];
            div_out[g].dq  = {div_in[g].dq[62:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
                div_reg[g] <= div_out[g];
        end
    end

    // the first divider stage registers the stage 10 word
    div_t  dlast;
    assign dlast = div_reg[DIV_STAGES-1];

    // quotient sign
    logic [63:0] q_next, q_reg, q1_reg, q2_reg, q3_reg, q4_reg;
    side_t       sq1_reg, sq2_reg, sq3_reg, sq4_reg, sq0_reg;
    logic [63:0] a13, m_sq, m_p8, m_p9, mp8_1_reg, mp8_2_reg;

    assign q_next = dlast.neg ? 64'd0 - dlast.dq : dlast.dq;
    assign a13    = {{13{q_reg[63]}}, q_reg[63:13]};

    ptc_mul64 u_mul_sq (
        .clk (clk),
        .en  (en),
        .a   (a13),
        .b   (a13),
        .p   (m_sq)
    );

    ptc_mul64 u_mul_p8 (
        .clk (clk),
        .en  (en),
        .a   (q_reg),
        .b   ({{48{p8[15]}}, p8}),
        .p   (m_p8)
    );

    ptc_mul64 u_mul_p9 (
        .clk (clk),
        .en  (en),
        .a   (m_sq),
        .b   ({{48{p9[15]}}, p9}),
        .p   (m_p9)
    );

    // output stage
    logic [63:0] sum, res;
    logic [31:0] press_next;

    always_comb
    begin
        sum = q4_reg + {{25{m_p9[63]}}, m_p9[63:25]}
            + {{19{mp8_2_reg[63]}}, mp8_2_reg[63:19]};
        res = {{8{sum[63]}}, sum[63:8]} + ({{48{p7[15]}}, p7} << 4);
        press_next = sq4_reg.fault ? 32'd0 : res[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            at2_reg    <= at2_next;
            dd_reg     <= dd_next;
            adc_p1_reg <= adc_p;
            v1t_reg    <= $signed(at2_reg[33:11]);
            x_reg      <= x_next;
            adc_p2_reg <= adc_p1_reg;
            tc3_reg    <= tc_next;
            pv1_reg    <= pv1_next;
            adc_p3_reg <= adc_p2_reg;
            sq_reg     <= sq_next;
            p5m_reg    <= p5m_next;
            p2m_reg    <= p2m_next;
            tc4_reg    <= tc3_reg;
            adc_p4_reg <= adc_p3_reg;
            p5m5_reg   <= p5m_reg;
            p5m6_reg   <= p5m5_reg;
            p2m5_reg   <= p2m_reg;
            p2m6_reg   <= p2m5_reg;
            tc5_reg    <= tc4_reg;
            tc6_reg    <= tc5_reg;
            adc_p5_reg <= adc_p4_reg;
            adc_p6_reg <= adc_p5_reg;
            v1_reg     <= v1_next;
            num0_reg   <= num0_next;
            tc7_reg    <= tc6_reg;
            tc8_reg    <= tc7_reg;
            tc9_reg    <= tc8_reg;
            q_reg      <= q_next;
            sq0_reg    <= dlast.side;
            q1_reg     <= q_reg;
            q2_reg     <= q1_reg;
            sq1_reg    <= sq0_reg;
            sq2_reg    <= sq1_reg;
            q3_reg     <= q2_reg;
            q4_reg     <= q3_reg;
            mp8_1_reg  <= m_p8;
            mp8_2_reg  <= mp8_1_reg;
            sq3_reg    <= sq2_reg;
            sq4_reg    <= sq3_reg;
            m_tdata    <= {press_next, sq4_reg.tc};
            m_tuser    <= sq4_reg.fault;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ptc_checker.sv =====
// port-level checker for the compensation block, bound to the top level
// depends on pressure_temperature_compensation_assert.svh
`default_nettype none

`include "pressure_temperature_compensation_assert.svh"

module ptc_port_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [0:0]  m_tuser,
    input wire logic        pready
);

    // a stalled result word holds
    `PTC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a divide fault always reports zero pressure
    `PTC_ASSERT_IMPL(a_fault_zero, m_tvalid && m_tuser[0], m_tdata[47:16] == 32'd0)

    // input side is open whenever the output can move
    `PTC_ASSERT_IMPL(a_ready_free, !m_tvalid || m_tready, s_tready)

    `PTC_ASSERT_IMPL(a_pready, 1'b1, pready)

endmodule

bind pressure_temperature_compensation ptc_port_checker u_ptc_checker (.*);

`default_nettype wire
